[design/chr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package chr_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned MANT_W = 23;
	localparam int unsigned SHIFT_W = 5;
	localparam int unsigned EXP_W = 8;

	localparam logic [WORD_W-1:0] HASH_K0 = 32'd576942909;
	localparam logic [WORD_W-1:0] HASH_K1 = 32'd1121052041;
	localparam logic [WORD_W-1:0] HASH_K2 = 32'd1040796640;
	localparam int unsigned FOLD_SHIFT = 16;
	localparam int unsigned MANT_SHIFT = 9;
	// Biased exponent of a mantissa whose leading one sits at bit 22 is 126.
	localparam logic [EXP_W-1:0] EXP_TOP = 8'd126;

	localparam logic MODE_INT = 1'b0;
	localparam logic MODE_FLOAT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_MUL2 = 5'b00100,
		ST_NORM = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage
`default_nettype wire

[design/chr_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
module chr_norm (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [chr_pkg::WORD_W-1:0] hash,
	output logic                            done,
	output logic      [chr_pkg::WORD_W-1:0] float_bits
);
	import chr_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [2:0]          step_q;
	logic [MANT_W-1:0]   mant_q;
	logic [SHIFT_W-1:0]  sh_q;
	logic [MANT_W-1:0]   mant_next;
	logic [SHIFT_W-1:0]  sh_next;
	logic [EXP_W-1:0]    exp_bits;

	// One step of a binary leading-zero search: try 16, 8, 4, 2 then 1 places.
	always_comb begin
		mant_next = mant_q;
		sh_next = sh_q;
		case (step_q)
			3'd0: begin
				if (mant_q[22:7] == '0) begin
					mant_next = {mant_q[6:0], 16'b0};
					sh_next = sh_q + 5'd16;
				end
			end
			3'd1: begin
				if (mant_q[22:15] == '0) begin
					mant_next = {mant_q[14:0], 8'b0};
					sh_next = sh_q + 5'd8;
				end
			end
			3'd2: begin
				if (mant_q[22:19] == '0) begin
					mant_next = {mant_q[18:0], 4'b0};
					sh_next = sh_q + 5'd4;
				end
			end
			3'd3: begin
				if (mant_q[22:21] == '0) begin
					mant_next = {mant_q[20:0], 2'b0};
					sh_next = sh_q + 5'd2;
				end
			end
			3'd4: begin
				if (mant_q[22] == 1'b0) begin
					mant_next = {mant_q[21:0], 1'b0};
					sh_next = sh_q + 5'd1;
				end
			end
			default: begin
				mant_next = mant_q;
				sh_next = sh_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mant_q <= hash[WORD_W-1:MANT_SHIFT];
			sh_q <= '0;
		end else if (busy_q) begin
			mant_q <= mant_next;
			sh_q <= sh_next;
		end
	end

	assign exp_bits = EXP_TOP - {{(EXP_W-SHIFT_W){1'b0}}, sh_q};
	assign done = done_q;
	// A zero mantissa gives +0.0; otherwise the leading one is implicit.
	assign float_bits = (mant_q == '0) ? '0 : {1'b0, exp_bits, mant_q[MANT_W-2:0], 1'b0};

endmodule
`default_nettype wire

[design/coordinate_hash_random.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each term runs through one shared 32x32 multiplier twice, in MUL1 and then MUL2,
// and a following term of the same run is taken in MUL2.
// A last term gives its word after MUL1 and MUL2 through EMIT in integer mode, and
// through NORM and EMIT in float mode, where a five-step leading-zero search follows;
// the next term can be taken as the word is raised; EMIT holds while the output is full.
// Reset clears the accumulator, the output mode and all control state but last_q.
module coordinate_hash_random (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [chr_pkg::WORD_W-1:0] term,
	input  wire logic                       last_term,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [chr_pkg::WORD_W-1:0] random_bits,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_wdata
);
	import chr_pkg::*;

	state_t              state_q;
	logic                mode_q;
	logic                last_q;
	logic [WORD_W-1:0]   acc_q;
	logic [WORD_W-1:0]   x_q;
	logic [WORD_W-1:0]   t_q;
	logic [WORD_W-1:0]   h_q;
	logic [WORD_W-1:0]   out_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   mul_a;
	logic [WORD_W-1:0]   product;
	logic [WORD_W-1:0]   poly;
	logic [WORD_W-1:0]   fold;
	logic                accept;
	logic                slot_free;
	logic                norm_start;
	logic                norm_done;
	logic [WORD_W-1:0]   norm_bits;

	// The shared multiplier: K2 * x in MUL1, t * x in MUL2.
	assign mul_a = (state_q == ST_MUL1) ? HASH_K2 : t_q;
	assign product = mul_a * x_q;
	assign poly = product[WORD_W-1:0] + HASH_K0;
	assign fold = poly ^ (poly >> FOLD_SHIFT);

	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_MUL2) && !last_q);
	assign accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign norm_start = (state_q == ST_MUL2) && last_q && (mode_q == MODE_FLOAT);

	chr_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (norm_start),
		.hash       (fold),
		.done       (norm_done),
		.float_bits (norm_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_INT;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (last_q) begin
						acc_q <= '0;
						state_q <= (mode_q == MODE_FLOAT) ? ST_NORM : ST_EMIT;
					end else if (accept) begin
						acc_q <= poly;
						state_q <= ST_MUL1;
					end else begin
						acc_q <= poly;
						state_q <= ST_IDLE;
					end
				end
				ST_NORM: begin
					if (norm_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// In the second multiply state (MUL2) the fresh accumulator is still in flight.
			x_q <= ((state_q == ST_MUL2) ? poly : acc_q) + term;
			last_q <= last_term;
		end
		if (state_q == ST_MUL1) begin
			t_q <= product[WORD_W-1:0] + HASH_K1;
		end
		if (state_q == ST_MUL2 && last_q) begin
			h_q <= fold;
		end else if (state_q == ST_NORM && norm_done) begin
			h_q <= norm_bits;
		end
		if (state_q == ST_EMIT && slot_free) begin
			out_q <= h_q;
		end
	end

	assign out_valid = out_valid_q;
	assign random_bits = out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken again in the cycle after a word was accepted");

	a_run_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL2 && !last_q && !accept) |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after a non-final term");

	a_norm_done_in_norm: assert property (@(posedge clk) disable iff (!arst_n)
		norm_done |-> state_q == ST_NORM)
		else $error("normaliser finished outside its state");

	a_norm_only_float: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NORM |-> mode_q == MODE_FLOAT)
		else $error("normalising while in integer mode");

endmodule
`default_nettype wire
